[rtl/core/swqc_pkg.sv]
// Shared types and constants for the sliding-window qualified count unit.
// Field widths, register indexes and reset values; no dependencies.
`default_nettype none

package swqc_pkg;

  localparam int MAX_WINDOW_DEF = 1024;
  localparam int POS_BITS_DEF   = 32;

  localparam int VALUE_W    = 16;
  localparam int WLEN_W     = 11;
  localparam int INV_W      = 17;
  localparam int POSITION_W = 32;
  localparam int COUNT_W    = 11;
  localparam int MEAN_W     = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_WINDOW = 1'd1;

  localparam logic [WLEN_W-1:0]  WLEN_RESET = 11'd32;
  localparam logic [INV_W-1:0]   INV_RESET  = 17'd2048;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 11'd2047;
  localparam logic [MEAN_W-1:0]  MEAN_MAX   = 17'd65536;

endpackage

`default_nettype wire

[rtl/core/swqc_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read-during-write to the same address returns the old data. No dependencies.
`default_nettype none

module swqc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/sliding_window_qualified_count_unit.sv]
// Sliding-window qualified count unit: top level.
// Depends on swqc_pkg and swqc_ram (flag ring storage).
//
// Usage:
//  - Input channel (in_valid/in_ready): one beat per position, carrying the
//    position value and a sequence-start mark. A value qualifies when it is
//    nonzero and at most the effective window (window_len clamped to
//    [1, MAX_WINDOW]).
//  - Output channel (out_valid/out_ready): one beat per position whose window
//    count is nonzero; positions with a zero count produce no beat.
//  - Config port: cfg_wr_en/cfg_index/cfg_wdata, write only, taken at once.
//    Write only while the block is idle (pipeline drained).
//  - Throughput: one beat per cycle unless the receiver stalls. The flag ring
//    is read (oldest flag) and written (newest flag) in the same cycle through
//    separate RAM ports; the running total is updated once per beat in stage 1.
//  - Pipeline: a result beat passes the RAM read, the total update and the mean
//    multiply/saturate, each into its own register, before the output shows it.
//  - Reset (synchronous, rst_n low): clears counters, running total, run flag
//    and pipeline valids; registers return to window_len 32 and reciprocal
//    2048. The flag ring is not cleared; only written entries are ever used.
//  - Receiver stall: the whole pipeline holds while the output register is
//    full and out_ready is low; in_ready drops in the same cycle.
`default_nettype none

module sliding_window_qualified_count_unit #(
  parameter int MAX_WINDOW = swqc_pkg::MAX_WINDOW_DEF,
  parameter int POS_BITS   = swqc_pkg::POS_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            in_valid,
  output      logic                            in_ready,
  input  wire logic [swqc_pkg::VALUE_W-1:0]    in_value_len,
  input  wire logic                            in_seq_start,
  // result channel
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      logic [swqc_pkg::POSITION_W-1:0] out_position,
  output      logic [swqc_pkg::COUNT_W-1:0]    out_window_count,
  output      logic [swqc_pkg::MEAN_W-1:0]     out_mean_q16,
  output      logic                            out_run_start,
  // configuration port
  input  wire logic                            cfg_wr_en,
  input  wire logic [swqc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [swqc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import swqc_pkg::*;

  // Ring index width, effective-window width and compare widths
  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WW = $clog2(MAX_WINDOW + 1);
  localparam int EW = (WW > WLEN_W) ? WW : WLEN_W;
  localparam int QW = (WW > VALUE_W) ? WW : VALUE_W;
  localparam int CW = (WW > POS_BITS) ? WW : POS_BITS;
  localparam int XW = (POS_BITS + 1 > POSITION_W) ? POS_BITS + 1 : POSITION_W;
  localparam int PW = WW + 1;
  localparam int MW = COUNT_W + INV_W;

  localparam logic [EW-1:0] MAX_E    = EW'(MAX_WINDOW);
  localparam logic [WW-1:0] MAX_W    = WW'(MAX_WINDOW);
  localparam logic [PW-1:0] MAX_P    = PW'(MAX_WINDOW);
  localparam logic [AW-1:0] PTR_LAST = AW'(MAX_WINDOW - 1);

  typedef struct packed {
    logic                  start;
    logic                  rd_valid;
    logic                  qual;
    logic [POSITION_W-1:0] position;
  } s1_t;

  typedef struct packed {
    logic [POSITION_W-1:0] position;
    logic [COUNT_W-1:0]    count;
    logic                  run_start;
  } s2_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [WLEN_W-1:0] wlen_r;
  logic [INV_W-1:0]  inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= WLEN_RESET;
      inv_r  <= INV_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_WINDOW_LEN: wlen_r <= cfg_wdata[WLEN_W-1:0];
        REG_INV_WINDOW: inv_r  <= cfg_wdata[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp window length to [1, MAX_WINDOW]
  logic [EW-1:0] wlen_ext;
  logic [WW-1:0] win_eff;

  assign wlen_ext = EW'(wlen_r);

  always_comb begin
    if (wlen_ext == '0) begin
      win_eff = WW'(1);
    end else if (wlen_ext > MAX_E) begin
      win_eff = MAX_W;
    end else begin
      win_eff = wlen_ext[WW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline advance: every stage moves when the output register can take data
  // ---------------------------------------------------------------------------
  logic out_valid_r;
  logic adv;
  logic in_accept;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign in_accept = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Stage 0: position and ring pointer, ring write of the new flag, ring read
  // of the flag leaving the window
  // ---------------------------------------------------------------------------
  logic [POS_BITS-1:0] pos_cnt_r, pos_cnt_nxt, pos_cur;
  logic [AW-1:0]       ptr_r, ptr_nxt, ptr_cur;
  logic [POS_BITS:0]   pos_inc;
  logic [XW-1:0]       pos_wide;
  logic [PW-1:0]       ptr_ext, win_p, rd_diff;
  logic [AW-1:0]       rd_addr;
  logic                rd_valid0;
  logic                qual0;
  logic [0:0]          ram_rdata;

  assign pos_cur     = in_seq_start ? '0 : pos_cnt_r;
  assign ptr_cur     = in_seq_start ? '0 : ptr_r;
  assign pos_inc     = {1'b0, pos_cur} + (POS_BITS + 1)'(1);
  assign pos_wide    = XW'(pos_inc);
  assign pos_cnt_nxt = pos_inc[POS_BITS-1:0];

  // Ring pointer tracks position modulo MAX_WINDOW; restart with the position
  // on a counter wrap
  always_comb begin
    if (pos_cnt_nxt == '0 || ptr_cur == PTR_LAST) begin
      ptr_nxt = '0;
    end else begin
      ptr_nxt = ptr_cur + AW'(1);
    end
  end

  assign rd_valid0 = CW'(pos_cur) >= CW'(win_eff);
  assign ptr_ext   = PW'(ptr_cur);
  assign win_p     = PW'(win_eff);
  assign rd_diff   = (ptr_ext < win_p) ? (ptr_ext + MAX_P - win_p) : (ptr_ext - win_p);
  assign rd_addr   = rd_diff[AW-1:0];

  assign qual0 = (in_value_len != '0) && (QW'(in_value_len) <= QW'(win_eff));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_cnt_r <= '0;
      ptr_r     <= '0;
    end else if (in_accept) begin
      pos_cnt_r <= pos_cnt_nxt;
      ptr_r     <= ptr_nxt;
    end
  end

  // Read and write share the accept; a same-address hit (full-size window)
  // returns the old flag, which is the one leaving the window
  swqc_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WINDOW)
  ) u_flag_ram (
    .clk   (clk),
    .we    (in_accept),
    .waddr (ptr_cur),
    .wdata (qual0),
    .re    (in_accept),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  s1_t  s1_r;
  logic s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_accept) begin
      s1_r.start    <= in_seq_start;
      s1_r.rd_valid <= rd_valid0;
      s1_r.qual     <= qual0;
      s1_r.position <= pos_wide[POSITION_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: read-modify-write of the running total and the run flag
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0] total_r, total_nxt, total_base, total_dec;
  logic               in_run_r, in_run_nxt, run_base;
  logic               drop;

  assign total_base = s1_r.start ? '0 : total_r;
  assign run_base   = s1_r.start ? 1'b0 : in_run_r;
  // Drop the leaving flag, saturating at zero; add the new one, saturating high
  assign drop       = s1_r.rd_valid && ram_rdata[0] && (total_base != '0);
  assign total_dec  = total_base - COUNT_W'(drop);
  assign total_nxt  = total_dec + COUNT_W'(s1_r.qual && (total_dec != COUNT_MAX));
  assign in_run_nxt = (total_nxt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= '0;
      in_run_r <= 1'b0;
    end else if (adv && s1_valid_r) begin
      total_r  <= total_nxt;
      in_run_r <= in_run_nxt;
    end
  end

  s2_t  s2_r;
  logic s2_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r && (total_nxt != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r.position  <= s1_r.position;
      s2_r.count     <= total_nxt;
      s2_r.run_start <= !run_base;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: mean = count * reciprocal, saturate, load output register
  // ---------------------------------------------------------------------------
  logic [MW-1:0]     product;
  logic [MEAN_W-1:0] mean_sat;

  assign product  = MW'(s2_r.count) * MW'(inv_r);
  assign mean_sat = (product > MW'(MEAN_MAX)) ? MEAN_MAX : product[MEAN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_position     <= s2_r.position;
      out_window_count <= s2_r.count;
      out_mean_q16     <= mean_sat;
      out_run_start    <= s2_r.run_start;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[bench/sliding_window_qualified_count_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for sliding_window_qualified_count_unit: a scoreboard predicts
// every result beat while tasks drive the input and register ports; out_ready
// comes from a process. Depends on swqc_pkg and the unit's RTL only.

typedef struct packed {
  logic [swqc_pkg::POSITION_W-1:0] position;
  logic [swqc_pkg::COUNT_W-1:0]    count;
  logic [swqc_pkg::MEAN_W-1:0]     mean;
  logic                            run_start;
} window_result_t;

class window_count_board;
  bit                              qual_ring[swqc_pkg::MAX_WINDOW_DEF];
  logic [swqc_pkg::COUNT_W-1:0]    running_total;
  logic [swqc_pkg::POSITION_W-1:0] next_pos;
  bit                              in_run;
  logic [swqc_pkg::WLEN_W-1:0]     window_len;
  logic [swqc_pkg::INV_W-1:0]      inv_window;
  window_result_t                  expected_counts[$];
  int                              mismatches;
  int                              checked;
  int                              peak_count;

  function new();
    running_total = '0;
    next_pos      = '0;
    in_run        = 1'b0;
    window_len    = swqc_pkg::WLEN_RESET;
    inv_window    = swqc_pkg::INV_RESET;
    mismatches    = 0;
    checked       = 0;
    peak_count    = 0;
  endfunction

  function void write_reg(logic [swqc_pkg::CFG_IDX_W-1:0] idx,
                          logic [swqc_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      swqc_pkg::REG_WINDOW_LEN: window_len = data[swqc_pkg::WLEN_W-1:0];
      swqc_pkg::REG_INV_WINDOW: inv_window = data[swqc_pkg::INV_W-1:0];
      default: ;
    endcase
  endfunction

  // Effective window: the register clamped to [1, MAX_WINDOW].
  function int unsigned span();
    int unsigned w;
    w = window_len;
    if (w < 1) w = 1;
    if (w > swqc_pkg::MAX_WINDOW_DEF) w = swqc_pkg::MAX_WINDOW_DEF;
    return w;
  endfunction

  function void note_position(logic [swqc_pkg::VALUE_W-1:0] value, bit seq_start);
    int unsigned     w;
    longint unsigned pos;
    longint unsigned mean;
    bit              qualifies;
    window_result_t  r;
    w = span();
    if (seq_start) begin
      next_pos      = '0;
      running_total = '0;
      in_run        = 1'b0;
    end
    pos = next_pos;
    // Drop the flag leaving the window, never below zero.
    if (pos >= w) begin
      if (qual_ring[(pos - w) % swqc_pkg::MAX_WINDOW_DEF] && running_total != 0)
        running_total = running_total - 1'b1;
    end
    qualifies = (value != 0) && (value <= w);
    qual_ring[pos % swqc_pkg::MAX_WINDOW_DEF] = qualifies;
    if (qualifies && running_total != swqc_pkg::COUNT_MAX)
      running_total = running_total + 1'b1;
    next_pos = next_pos + 1'b1;
    if (running_total == 0) begin
      in_run = 1'b0;
      return;
    end
    mean = 64'(running_total) * 64'(inv_window);
    if (mean > swqc_pkg::MEAN_MAX) mean = swqc_pkg::MEAN_MAX;
    r.position  = next_pos;
    r.count     = running_total;
    r.mean      = mean[swqc_pkg::MEAN_W-1:0];
    r.run_start = !in_run;
    expected_counts.insert(expected_counts.size(), r);
    in_run = 1'b1;
    if (running_total > peak_count) peak_count = running_total;
  endfunction

  function void compare_field(string field, longint unsigned want, longint unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  function void check_result(window_result_t got);
    window_result_t want;
    if (expected_counts.size() == 0) begin
      mismatches++;
      $display("%0t ns: result beat with none pending, position %0d count %0d",
               $time, got.position, got.count);
      return;
    end
    want = expected_counts.pop_front();
    checked++;
    compare_field("position", want.position, got.position);
    compare_field("window_count", want.count, got.count);
    compare_field("mean_q16", want.mean, got.mean);
    compare_field("run_start", want.run_start, got.run_start);
  endfunction
endclass

module sliding_window_qualified_count_unit_tb;
  import swqc_pkg::*;

  typedef enum {FILL_QUALIFYING, FILL_REJECTED, FILL_MIXED} fill_t;

  localparam int ITEMS_TOTAL = 1950;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [VALUE_W-1:0]    in_value_len = '0;
  logic                  in_seq_start = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [POSITION_W-1:0] out_position;
  logic [COUNT_W-1:0]    out_window_count;
  logic [MEAN_W-1:0]     out_mean_q16;
  logic                  out_run_start;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  window_count_board board;
  int unsigned       stall_left = 0;
  bit                tx_idle = 1'b0;
  bit                rx_idle = 1'b0;
  int                beats_sent = 0;
  int                settings_used = 0;

  always #10 clk = ~clk;

  sliding_window_qualified_count_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value_len     (in_value_len),
    .in_seq_start     (in_seq_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_position     (out_position),
    .out_window_count (out_window_count),
    .out_mean_q16     (out_mean_q16),
    .out_run_start    (out_run_start),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // Idle length: mostly none or a few cycles, now and then a long stretch.
  function automatic int unsigned gap_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  // Result side: check every accepted beat against the oldest prediction, then
  // decide ready for the next cycle. A stall is always followed by one ready
  // cycle so a result never waits longer than one stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_result(window_result_t'{out_position, out_window_count,
                                          out_mean_q16, out_run_start});
    if (stall_left > 1) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left == 1) begin
      stall_left = 0;
      out_ready <= 1'b1;
    end else if (rx_idle) begin
      stall_left = gap_length();
      out_ready <= (stall_left == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Present one position and hold it until the handshake; keep valid high
  // straight into the next beat unless a gap is drawn.
  task automatic send_position(logic [VALUE_W-1:0] value, bit start);
    int unsigned gap;
    in_valid     <= 1'b1;
    in_value_len <= value;
    in_seq_start <= start;
    do @(posedge clk); while (!in_ready);
    board.note_position(value, start);
    beats_sent++;
    gap = tx_idle ? gap_length() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the sender until every predicted beat is out, then let the pipeline
  // settle past its latency (zero-count positions leave no beat).
  task automatic drain();
    in_valid <= 1'b0;
    while (board.expected_counts.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    board.write_reg(idx, data);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(logic [WLEN_W-1:0] wlen, logic [INV_W-1:0] inv);
    drain();
    write_reg(REG_WINDOW_LEN, CFG_DATA_W'(wlen));
    write_reg(REG_INV_WINDOW, CFG_DATA_W'(inv));
    settings_used++;
  endtask

  // Stream n positions of one flavor; a fresh stream opens a new sequence.
  task automatic feed_run(int unsigned n, fill_t fill, bit fresh);
    int unsigned        w;
    int unsigned        roll;
    logic [VALUE_W-1:0] value;
    bit                 start;
    for (int unsigned i = 0; i < n; i++) begin
      w     = board.span();
      roll  = $urandom_range(0, 99);
      start = fresh && (i == 0);
      case (fill)
        FILL_QUALIFYING: value = VALUE_W'($urandom_range(1, w));
        FILL_REJECTED:   value = (roll < 30) ? '0 : VALUE_W'($urandom_range(w + 1, 65535));
        default: begin
          if (roll < 18)      value = '0;
          else if (roll < 60) value = VALUE_W'($urandom_range(1, w));
          else if (roll < 70) value = VALUE_W'(w);
          else if (roll < 82) value = VALUE_W'($urandom_range(w + 1, 65535));
          else if (roll < 85) value = '1;
          else                value = VALUE_W'($urandom());
          if ($urandom_range(0, 79) == 0) start = 1'b1;
        end
      endcase
      send_position(value, start);
      // Occasionally hold the sender mid-stream until the output is empty.
      if (fill == FILL_MIXED && $urandom_range(0, 199) == 0) drain();
    end
  endtask

  initial begin
    #(40_000_000);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [WLEN_W-1:0] wlen;
    logic [INV_W-1:0]  inv;
    int unsigned       roll;
    int                n;
    fill_t             phase_fill;
    board = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers (window 32): empty value, upper limit, just above it,
    // all-ones value, then a new sequence in the middle of a run.
    send_position(16'd0, 1'b1);
    send_position(16'd32, 1'b0);
    send_position(16'd33, 1'b0);
    send_position(16'hFFFF, 1'b0);
    send_position(16'd1, 1'b0);
    send_position(16'd1, 1'b1);

    // Window of one: runs break on the zero count and restart.
    apply_setting(11'd1, 17'd65536);
    send_position(16'd1, 1'b1);
    send_position(16'd1, 1'b0);
    send_position(16'd0, 1'b0);
    send_position(16'd1, 1'b0);
    send_position(16'd2, 1'b0);

    // Widen to two mid-sequence: the first removal hits a flagged position
    // while the total is already zero, so the total must stay at zero.
    // The all-ones reciprocal forces the mean into saturation.
    apply_setting(11'd2, 17'h1FFFF);
    send_position(16'd0, 1'b0);
    send_position(16'd1, 1'b0);
    send_position(16'd2, 1'b0);

    // Zero window clamps to one; zero reciprocal gives a zero mean.
    apply_setting(11'd0, 17'd0);
    send_position(16'd1, 1'b1);
    send_position(16'h8000, 1'b0);

    // Register at its top clamps to the largest window.
    apply_setting(11'd2047, 17'd1);
    send_position(16'd1024, 1'b1);
    send_position(16'd1025, 1'b0);
    send_position(16'd512, 1'b0);

    // Random phases: new registers, new idle pattern, mostly new sequences.
    while (beats_sent < ITEMS_TOTAL) begin
      roll = $urandom_range(0, 99);
      if (roll < 30)      wlen = WLEN_W'($urandom_range(1, 8));
      else if (roll < 55) wlen = WLEN_W'($urandom_range(9, 64));
      else if (roll < 70) wlen = WLEN_W'($urandom_range(65, 300));
      else if (roll < 78) wlen = 11'd1024;
      else if (roll < 84) wlen = '0;
      else if (roll < 90) wlen = WLEN_W'($urandom_range(1025, 2047));
      else                wlen = WLEN_W'($urandom_range(0, 2047));
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        if (wlen == 0)         inv = 17'd65536;
        else if (wlen > 1024)  inv = 17'd64;
        else                   inv = INV_W'(65536 / wlen);
      end
      else if (roll < 55) inv = INV_W'($urandom_range(0, 65536));
      else if (roll < 65) inv = 17'd65536;
      else if (roll < 72) inv = '0;
      else if (roll < 80) inv = '1;
      else                inv = INV_W'($urandom());
      apply_setting(wlen, inv);
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      roll = $urandom_range(0, 99);
      if (roll < 10)      phase_fill = FILL_QUALIFYING;
      else if (roll < 16) phase_fill = FILL_REJECTED;
      else                phase_fill = FILL_MIXED;
      n = $urandom_range(20, 160);
      if (n > ITEMS_TOTAL - beats_sent) n = ITEMS_TOTAL - beats_sent;
      feed_run(n, phase_fill, $urandom_range(0, 9) < 7);
    end

    drain();
    $display("Ran %0d positions through %0d register settings; %0d result beats checked,",
             beats_sent, settings_used, board.checked);
    $display("highest window count seen %0d.", board.peak_count);
    if (board.mismatches == 0 && board.expected_counts.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
